/* rtl/core/rgbds_pkg.sv */
// ----------------------------------------------------------------------------
// rgbds_pkg
// Types and constants shared by the RGB weighted downsampler.
// ----------------------------------------------------------------------------
package rgbds_pkg;

	localparam int PIX_W       = 8;
	localparam int SIZE_W      = 12;
	localparam int FACTOR_W    = 3;
	localparam int PHASE_W     = 2;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 12;

	// Horizontal sum of one block row: at most 6 * 255.
	localparam int ROW_SUM_W = 11;
	// Weighted block sum: at most 36 * 255.
	localparam int COL_SUM_W = 14;
	localparam int CHANNELS  = 3;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_SHRINK = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT = 2'd2;

	localparam logic [FACTOR_W-1:0] FACTOR_2 = 3'd2;
	localparam logic [FACTOR_W-1:0] FACTOR_3 = 3'd3;
	localparam logic [FACTOR_W-1:0] FACTOR_4 = 3'd4;

	localparam logic [FACTOR_W-1:0] SHRINK_RESET = FACTOR_2;
	localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 12'd640;
	localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 12'd480;

	// floor(x / 3) = (x * 2731) >> 13 for any 12-bit x
	localparam logic [11:0] DIV3_MUL   = 12'd2731;
	localparam int          DIV3_SHIFT = 13;
	// floor(x / 9) = (x * 1821) >> 14 for x up to 2295
	localparam logic [10:0] DIV9_MUL   = 11'd1821;
	localparam int          DIV9_SHIFT = 14;

	// Result buffer
	localparam int OBUF_DEPTH = 2;
	localparam int OBUF_PW    = 1;
	localparam int OBUF_CW    = 2;

	typedef struct packed {
		logic [PIX_W-1:0] red_in;
		logic [PIX_W-1:0] green_in;
		logic [PIX_W-1:0] blue_in;
	} pix_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_out;
		logic [PIX_W-1:0] green_out;
		logic [PIX_W-1:0] blue_out;
		logic             row_end;
		logic             frame_end;
	} pix_out_t;

	typedef logic [CHANNELS-1:0][ROW_SUM_W-1:0] row_sums_t;
	typedef logic [CHANNELS-1:0][COL_SUM_W-1:0] col_sums_t;

endpackage

/* rtl/core/rgbds_obuf.sv */
// ----------------------------------------------------------------------------
// rgbds_obuf
// Two-entry result buffer that decouples the pipeline from output stall.
// ----------------------------------------------------------------------------
module rgbds_obuf import rgbds_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pix_out_t           push_data,
	output logic               valid,
	input  logic               stall,
	output pix_out_t           data,
	output logic [OBUF_CW-1:0] count
);

	pix_out_t             entry_q [OBUF_DEPTH];
	logic [OBUF_PW-1:0]   wr_ptr_q;
	logic [OBUF_PW-1:0]   rd_ptr_q;
	logic [OBUF_CW-1:0]   count_q;
	logic                 pop;

	assign valid = (count_q != '0);
	assign data  = entry_q[rd_ptr_q];
	assign count = count_q;
	assign pop   = valid && !stall;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pipeline never pushes into a full buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/rgb_weighted_downsampler.sv */
// ----------------------------------------------------------------------------
// rgb_weighted_downsampler
// Weighted-kernel RGB frame decimation by 2, 3 or 4 over a column-sum line store.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while pixel_stall is low; the line store has one
// read and one write port. A closed block passes the line-store read stage and the
// normalization stage into the result buffer. After reset and after each
// configuration write, pixel input stalls while frame geometry is recomputed.
// Reset clears configuration to factor 2, 640 x 480 and puts the raster at frame start;
// line store contents stay undefined.
module rgb_weighted_downsampler import rgbds_pkg::*; #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pixel_valid,
	output logic                   pixel_stall,
	input  pix_in_t                pixel,
	output logic                   result_valid,
	input  logic                   result_stall,
	output pix_out_t               result,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int STORE_COLS = MAX_WIDTH / 2;
	localparam int AW = $clog2(STORE_COLS);
	localparam int CW = ($clog2(MAX_WIDTH) < SIZE_W) ? $clog2(MAX_WIDTH) : SIZE_W;
	localparam int RW = ($clog2(MAX_HEIGHT) < SIZE_W) ? $clog2(MAX_HEIGHT) : SIZE_W;

	function automatic logic tap_double(input logic [FACTOR_W-1:0] f,
		input logic [PHASE_W-1:0] p);
		logic r;
		r = 1'b0;
		if (f == FACTOR_3) begin
			r = (p == 2'd1);
		end else if (f == FACTOR_4) begin
			r = (p == 2'd1) || (p == 2'd2);
		end
		return r;
	endfunction

	function automatic logic [PIX_W-1:0] kernel_div(input logic [FACTOR_W-1:0] f,
		input logic [COL_SUM_W-1:0] x);
		logic [COL_SUM_W-3:0]    q4;
		logic [COL_SUM_W-3+11:0] prod;
		logic [PIX_W-1:0]        r;
		q4   = x[COL_SUM_W-1:2];
		prod = q4 * DIV9_MUL;
		if (f == FACTOR_3) begin
			r = PIX_W'(x >> 4);
		end else if (f == FACTOR_4) begin
			r = PIX_W'(prod >> DIV9_SHIFT);
		end else begin
			r = PIX_W'(q4);
		end
		return r;
	endfunction

	// Configuration registers
	logic [FACTOR_W-1:0] shrink_q;
	logic [SIZE_W-1:0]   width_q;
	logic [SIZE_W-1:0]   height_q;
	logic                cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready &&
		(cfg_index == CFG_SHRINK || cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shrink_q <= SHRINK_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SHRINK: shrink_q <= cfg_data[FACTOR_W-1:0];
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data;
				default:    shrink_q <= shrink_q;
			endcase
		end
	end

	// Geometry, first step: factor, clamped size, block counts
	logic [FACTOR_W-1:0] f_a;
	logic [SIZE_W-1:0]   w_a;
	logic [SIZE_W-1:0]   h_a;
	logic [SIZE_W+11:0]  w3_prod;
	logic [SIZE_W+11:0]  h3_prod;
	logic [SIZE_W-1:0]   nx_a;
	logic [SIZE_W-1:0]   ny_a;

	always_comb begin
		f_a = (shrink_q == FACTOR_3 || shrink_q == FACTOR_4) ? shrink_q : FACTOR_2;
		if (width_q == '0) begin
			w_a = SIZE_W'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_a = SIZE_W'(MAX_WIDTH);
		end else begin
			w_a = width_q;
		end
		if (height_q == '0) begin
			h_a = SIZE_W'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_a = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_a = height_q;
		end
		w3_prod = w_a * DIV3_MUL;
		h3_prod = h_a * DIV3_MUL;
		if (f_a == FACTOR_3) begin
			nx_a = SIZE_W'(w3_prod >> DIV3_SHIFT);
			ny_a = SIZE_W'(h3_prod >> DIV3_SHIFT);
		end else if (f_a == FACTOR_4) begin
			nx_a = w_a >> 2;
			ny_a = h_a >> 2;
		end else begin
			nx_a = w_a >> 1;
			ny_a = h_a >> 1;
		end
	end

	logic [FACTOR_W-1:0] f_q;
	logic [CW-1:0]       w_m1_q;
	logic [RW-1:0]       h_m1_q;
	logic [SIZE_W-1:0]   nx_q;
	logic [SIZE_W-1:0]   ny_q;

	always_ff @(posedge clk) begin
		f_q    <= f_a;
		w_m1_q <= CW'(w_a - 1'b1);
		h_m1_q <= RW'(h_a - 1'b1);
		nx_q   <= nx_a;
		ny_q   <= ny_a;
	end

	// Geometry, second step: used area and last output column
	logic [SIZE_W-1:0] used_w;
	logic [SIZE_W-1:0] used_h;
	logic [CW-1:0]     used_w_m1_q;
	logic [RW-1:0]     used_h_m1_q;
	logic [AW-1:0]     nx_m1_q;
	logic              nx_ok_q;
	logic              ny_ok_q;

	always_comb begin
		if (f_q == FACTOR_3) begin
			used_w = nx_q + (nx_q << 1);
			used_h = ny_q + (ny_q << 1);
		end else if (f_q == FACTOR_4) begin
			used_w = nx_q << 2;
			used_h = ny_q << 2;
		end else begin
			used_w = nx_q << 1;
			used_h = ny_q << 1;
		end
	end

	always_ff @(posedge clk) begin
		used_w_m1_q <= CW'(used_w - 1'b1);
		used_h_m1_q <= RW'(used_h - 1'b1);
		nx_m1_q     <= AW'(nx_q - 1'b1);
		nx_ok_q     <= (nx_q != '0);
		ny_ok_q     <= (ny_q != '0);
	end

	// Hold input until both geometry steps have settled.
	logic [1:0] derive_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			derive_cnt_q <= 2'd2;
		end else if (cfg_we) begin
			derive_cnt_q <= 2'd2;
		end else if (derive_cnt_q != 2'd0) begin
			derive_cnt_q <= derive_cnt_q - 2'd1;
		end
	end

	// Raster position
	logic [CW-1:0]      in_col_q;
	logic [RW-1:0]      in_row_q;
	logic [PHASE_W-1:0] phase_x_q;
	logic [PHASE_W-1:0] phase_y_q;
	logic [AW-1:0]      out_col_q;

	logic [PHASE_W-1:0] f_m1;
	logic               col_in;
	logic               row_in;
	logic               active;
	logic               first_x;
	logic               last_x;
	logic               first_y;
	logic               last_y;
	logic               emit;
	logic               accept;
	logic               row_end;
	logic               frame_end;

	logic               s1_valid;
	logic               s1_emit;
	logic               s2_emit;
	logic [OBUF_CW-1:0] obuf_count;
	logic [2:0]         inflight;

	assign f_m1    = PHASE_W'(f_q - 1'b1);
	assign col_in  = nx_ok_q && (in_col_q <= used_w_m1_q);
	assign row_in  = ny_ok_q && (in_row_q <= used_h_m1_q);
	assign active  = col_in && row_in;
	assign first_x = (phase_x_q == '0);
	assign last_x  = (phase_x_q == f_m1);
	assign first_y = (phase_y_q == '0);
	assign last_y  = (phase_y_q == f_m1);
	assign emit    = active && last_x && last_y;

	assign row_end   = (out_col_q == nx_m1_q);
	assign frame_end = row_end && (in_row_q == used_h_m1_q);

	assign inflight    = 3'(obuf_count) + 3'(s1_valid && s1_emit) + 3'(s2_emit);
	assign pixel_stall = (derive_cnt_q != 2'd0) || (emit && inflight >= 3'(OBUF_DEPTH));
	assign accept      = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			phase_x_q <= '0;
			phase_y_q <= '0;
			out_col_q <= '0;
		end else if (cfg_we) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			phase_x_q <= '0;
			phase_y_q <= '0;
			out_col_q <= '0;
		end else if (accept) begin
			if (active) begin
				if (last_x) begin
					out_col_q <= out_col_q + 1'b1;
					phase_x_q <= '0;
				end else begin
					phase_x_q <= phase_x_q + 1'b1;
				end
			end
			if (in_col_q == w_m1_q) begin
				in_col_q  <= '0;
				phase_x_q <= '0;
				out_col_q <= '0;
				if (in_row_q == h_m1_q) begin
					in_row_q  <= '0;
					phase_y_q <= '0;
				end else begin
					in_row_q <= in_row_q + 1'b1;
					if (row_in) begin
						phase_y_q <= last_y ? '0 : phase_y_q + 1'b1;
					end
				end
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
		end
	end

	// Horizontal block-row sum
	row_sums_t              rbs_q;
	row_sums_t              rbs_next;
	logic [CHANNELS-1:0][PIX_W-1:0] pix;
	logic                   wx2;

	assign pix = {pixel.red_in, pixel.green_in, pixel.blue_in};
	assign wx2 = tap_double(f_q, phase_x_q);

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			rbs_next[c] = (first_x ? '0 : rbs_q[c]) +
				(wx2 ? ROW_SUM_W'({pix[c], 1'b0}) : ROW_SUM_W'(pix[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active) begin
			rbs_q <= rbs_next;
		end
	end

	// Line store of column sums: read on block close, written back in the next cycle.
	// The same column comes back no sooner than one input row later, so a
	// write always lands before the next read of its entry.
	col_sums_t col_mem [STORE_COLS];
	col_sums_t col_rd_s1;
	logic      rd_en;

	assign rd_en = accept && active && last_x;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			col_rd_s1 <= col_mem[out_col_q];
		end
	end

	logic [AW-1:0] addr_s1;
	logic          first_y_s1;
	logic          wy2_s1;
	row_sums_t     rbs_s1;
	logic          row_end_s1;
	logic          frame_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_emit  <= 1'b0;
		end else begin
			s1_valid <= rd_en;
			s1_emit  <= rd_en && last_y;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1      <= out_col_q;
			first_y_s1   <= first_y;
			wy2_s1       <= tap_double(f_q, phase_y_q);
			rbs_s1       <= rbs_next;
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
		end
	end

	col_sums_t col_new;

	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			col_new[c] = (first_y_s1 ? '0 : col_rd_s1[c]) +
				(wy2_s1 ? COL_SUM_W'({rbs_s1[c], 1'b0}) : COL_SUM_W'(rbs_s1[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			col_mem[addr_s1] <= col_new;
		end
	end

	// Kernel normalization
	col_sums_t sum_s2;
	logic      row_end_s2;
	logic      frame_end_s2;
	pix_out_t  res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_emit <= 1'b0;
		end else begin
			s2_emit <= s1_valid && s1_emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid && s1_emit) begin
			sum_s2       <= col_new;
			row_end_s2   <= row_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	always_comb begin
		res_s2.red_out   = kernel_div(f_q, sum_s2[2]);
		res_s2.green_out = kernel_div(f_q, sum_s2[1]);
		res_s2.blue_out  = kernel_div(f_q, sum_s2[0]);
		res_s2.row_end   = row_end_s2;
		res_s2.frame_end = frame_end_s2;
	end

	rgbds_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (s2_emit),
		.push_data (res_s2),
		.valid     (result_valid),
		.stall     (result_stall),
		.data      (result),
		.count     (obuf_count)
	);

endmodule
